[rtl/cpts_pkg.sv]
// Shared constants and types for the counter priority task scheduler.
// No dependencies; imported by cpts_cnt_store and the top level.
package cpts_pkg;

    localparam int NUM_TASKS = 8;              // tasks scanned and reloaded, 2..8
    localparam int TASK_W    = 3;              // task index width (fixed by the ports)
    localparam int CNT_W     = 4;              // slice counter width
    localparam int MASK_W    = 8;              // runnable mask width
    localparam int CFG_AW    = 3;              // config register index width
    localparam int CFG_DW    = 8;              // config write data width
    localparam int NUM_SLOTS = 1 << TASK_W;    // counter store depth
    localparam int SCAN_W    = $clog2(NUM_TASKS + 1);

    // config register indexes
    localparam logic [CFG_AW-1:0] CFG_RUNNABLE = CFG_AW'(0);

    // write beat into the counter store
    typedef struct packed {
        logic              en;
        logic [TASK_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } cnt_wr_t;

endpackage

[rtl/cpts_cnt_store.sv]
// Slice counter store: synchronous RAM, one write and one read port,
// registered read, per-entry valid bits so unwritten entries read zero.
// Depends on cpts_pkg.
module cpts_cnt_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpts_pkg::cnt_wr_t             wr,
    input  logic [cpts_pkg::TASK_W-1:0]   raddr,
    output logic [cpts_pkg::CNT_W-1:0]    rdata
);
    import cpts_pkg::*;

    logic [CNT_W-1:0]     mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0]     rdata_reg;
    logic                 rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rvld_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

[rtl/counter_priority_task_scheduler_top.sv]
// Counter priority task scheduler, top level.
// Depends on cpts_pkg and cpts_cnt_store.
//
// Usage:
//   Command channel: pulse start with tick while busy is low; that beat is
//   taken at the clock edge. A tick charges one slice unit to the running
//   task and reschedules when needed; tick = 0 only reports status.
//   Result channel: done is high for exactly one cycle with running_task,
//   switched, reloaded, idle_fallback and slice_left. The receiver cannot
//   stall; the result must be captured in that cycle.
//   Config port: cfg_we/cfg_addr/cfg_wdata write register cfg_addr at the
//   edge (0 = runnable mask, 1..7 = task priorities). Write only when idle.
// Sequence (start edge to done):
//   status only or no reschedule: counter read, then check/update.
//   reschedule: counter read, check, a scan of the counters, decide; the scan
//   reads one counter per cycle from the single read port of the store.
//   reschedule with reload: add NUM_TASKS reload writes plus a second scan
//   and decide.
//   A new beat can be taken at the edge that ends the done cycle (busy
//   drops with done).
// Reset: current task is idle, all counters read zero via valid bits (no
//   clearing pass), runnable mask is all ones, priorities 1..7 are 1.
module counter_priority_task_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          tick,
    output logic                          done,
    output logic [cpts_pkg::TASK_W-1:0]   running_task,
    output logic                          switched,
    output logic                          reloaded,
    output logic                          idle_fallback,
    output logic [cpts_pkg::CNT_W-1:0]    slice_left,
    input  logic                          cfg_we,
    input  logic [cpts_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [cpts_pkg::CFG_DW-1:0]   cfg_wdata
);
    import cpts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RELOAD = 3'd4;

    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NUM_TASKS);
    localparam logic [SCAN_W-1:0] LAST_IDX = SCAN_W'(NUM_TASKS - 1);

    // config registers
    logic [MASK_W-1:0] runnable_reg;
    logic [CNT_W-1:0]  prio_reg [NUM_SLOTS];

    // control state
    logic [2:0]        state_reg, state_next;
    logic              tick_reg, tick_next;
    logic [TASK_W-1:0] cur_reg, cur_next;
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [TASK_W-1:0] pend_idx_reg, pend_idx_next;
    logic [TASK_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic              rld_reg, rld_next;
    logic [SCAN_W-1:0] rld_idx_reg, rld_idx_next;

    // result registers
    logic              done_reg, done_next;
    logic [TASK_W-1:0] task_reg, task_next;
    logic              sw_reg, sw_next;
    logic              rl_reg, rl_next;
    logic              fb_reg, fb_next;
    logic [CNT_W-1:0]  slice_reg, slice_next;

    // counter store
    cnt_wr_t           wr;
    logic [TASK_W-1:0] raddr;
    logic [CNT_W-1:0]  rdata;
    logic [CNT_W-1:0]  dec_cnt;

    cpts_cnt_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    // config writes; priority of idle stays zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runnable_reg <= '1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                prio_reg[i] <= (i == 0) ? CNT_W'(0) : CNT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_RUNNABLE)
            begin
                runnable_reg <= cfg_wdata[MASK_W-1:0];
            end
            else
            begin
                prio_reg[cfg_addr] <= cfg_wdata[CNT_W-1:0];
            end
        end
    end

    assign dec_cnt = rdata - CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        cur_next      = cur_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        rld_next      = rld_reg;
        rld_idx_next  = rld_idx_reg;
        done_next     = 1'b0;
        task_next     = task_reg;
        sw_next       = sw_reg;
        rl_next       = rl_reg;
        fb_next       = fb_reg;
        slice_next    = slice_reg;
        wr            = '0;
        raddr         = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // store reads the running task's counter at this edge
                if (start)
                begin
                    tick_next  = tick;
                    rld_next   = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!tick_reg)
                begin
                    done_next  = 1'b1;
                    task_next  = cur_reg;
                    sw_next    = 1'b0;
                    rl_next    = 1'b0;
                    fb_next    = 1'b0;
                    slice_next = rdata;
                    state_next = S_IDLE;
                end
                else if (cur_reg == '0 || rdata == '0 || dec_cnt == '0)
                begin
                    // charge the slice if there is one, then reschedule
                    if (cur_reg != '0 && rdata != '0)
                    begin
                        wr.en   = 1'b1;
                        wr.addr = cur_reg;
                        wr.data = dec_cnt;
                    end
                    scan_idx_next = '0;
                    best_cnt_next = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    wr.en      = 1'b1;
                    wr.addr    = cur_reg;
                    wr.data    = dec_cnt;
                    done_next  = 1'b1;
                    task_next  = cur_reg;
                    sw_next    = 1'b0;
                    rl_next    = 1'b0;
                    fb_next    = 1'b0;
                    slice_next = dec_cnt;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // issue one read, compare the one issued last cycle
                raddr = TASK_W'(scan_idx_reg);
                if (pend_reg && runnable_reg[pend_idx_reg] && rdata > best_cnt_reg)
                begin
                    best_next     = pend_idx_reg;
                    best_cnt_next = rdata;
                end
                if (scan_idx_reg == SCAN_END)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = TASK_W'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                end
            end
            S_DECIDE:
            begin
                if (best_cnt_reg != '0)
                begin
                    cur_next   = best_reg;
                    done_next  = 1'b1;
                    task_next  = best_reg;
                    sw_next    = (best_reg != cur_reg);
                    rl_next    = rld_reg;
                    fb_next    = 1'b0;
                    slice_next = best_cnt_reg;
                    state_next = S_IDLE;
                end
                else if (!rld_reg)
                begin
                    rld_next     = 1'b1;
                    rld_idx_next = '0;
                    state_next   = S_RELOAD;
                end
                else
                begin
                    // nothing even after reload: idle, whose counter is zero
                    cur_next   = '0;
                    done_next  = 1'b1;
                    task_next  = '0;
                    sw_next    = (cur_reg != '0);
                    rl_next    = 1'b1;
                    fb_next    = 1'b1;
                    slice_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_RELOAD:
            begin
                wr.en   = 1'b1;
                wr.addr = TASK_W'(rld_idx_reg);
                wr.data = prio_reg[TASK_W'(rld_idx_reg)];
                if (rld_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    best_cnt_next = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    rld_idx_next = rld_idx_reg + SCAN_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= 1'b0;
            cur_reg      <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            rld_reg      <= 1'b0;
            rld_idx_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            cur_reg      <= cur_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            rld_reg      <= rld_next;
            rld_idx_reg  <= rld_idx_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        task_reg     <= task_next;
        sw_reg       <= sw_next;
        rl_reg       <= rl_next;
        fb_reg       <= fb_next;
        slice_reg    <= slice_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign running_task  = task_reg;
    assign switched      = sw_reg;
    assign reloaded      = rl_reg;
    assign idle_fallback = fb_reg;
    assign slice_left    = slice_reg;

    // result beat always ends a command, never overlaps one
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // accepted command keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // idle fallback only after a reload, and reports idle with no slice
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (done && idle_fallback) |-> (reloaded && running_task == '0 && slice_left == '0))
        else $error("bad idle fallback result");

    // a task picked by the scan always has slice left
    a_pick_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched && !idle_fallback) |-> (slice_left != '0))
        else $error("switched to a task without slice");

    // the running task never leaves the scanned range
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(running_task) < NUM_TASKS))
        else $error("running task out of range");

endmodule
